FILE: src/privileged_csr_trap_emulator_core_macros.svh
// Assertion macros for the privileged CSR trap emulator core.
// They expect the including module to have clk and arst_n in scope.
`ifndef PRIVILEGED_CSR_TRAP_EMULATOR_CORE_MACROS_SVH
`define PRIVILEGED_CSR_TRAP_EMULATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/pcte_pkg.sv
// Shared types, constants and tables of the privileged CSR trap emulator.
// Used by every module of the block; depends on nothing.
package pcte_pkg;

	// Number of entries in the CSR store and in the address table.
	localparam int NUM_CSRS  = 36;
	localparam int TABLE_LEN = 36;

	// Table index width and memory address width.
	localparam int CSR_IX_W = $clog2(TABLE_LEN);
	localparam int MEM_AW   = (NUM_CSRS > 1) ? $clog2(NUM_CSRS) : 1;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Stream payload widths.
	localparam int IN_TDATA_W  = 160;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_BITS    = 137;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Privilege modes.
	localparam logic [1:0] MODE_U = 2'd0;
	localparam logic [1:0] MODE_S = 2'd1;
	localparam logic [1:0] MODE_M = 2'd2;

	// Instruction fields that select sret and mret.
	localparam logic [11:0] SRET_FIELD = 12'h102;
	localparam logic [11:0] MRET_FIELD = 12'h302;

	localparam logic [2:0] F3_SYSTEM = 3'd0;
	localparam logic [2:0] F3_CSRW   = 3'd1;
	localparam logic [2:0] F3_CSRR   = 3'd2;

	// Store entries with a fixed role.
	localparam logic [CSR_IX_W-1:0] IX_SSTATUS = CSR_IX_W'(8);
	localparam logic [CSR_IX_W-1:0] IX_STVEC   = CSR_IX_W'(12);
	localparam logic [CSR_IX_W-1:0] IX_SEPC    = CSR_IX_W'(14);
	localparam logic [CSR_IX_W-1:0] IX_VENDOR  = CSR_IX_W'(20);
	localparam logic [CSR_IX_W-1:0] IX_MSTATUS = CSR_IX_W'(24);
	localparam logic [CSR_IX_W-1:0] IX_MEPC    = CSR_IX_W'(30);

	localparam logic [63:0] VENDOR_ID = 64'hC5E536;

	// Status bit positions.
	localparam int SIE_BIT  = 1;
	localparam int MIE_BIT  = 3;
	localparam int SPIE_POS = 5;
	localparam int MPIE_POS = 7;
	localparam int SPP_BIT  = 8;
	localparam int MPP_LO   = 11;
	localparam int MPP_HI   = 12;

	// Address code and minimum privilege of every table entry.
	localparam logic [11:0] CSR_CODE [TABLE_LEN] = '{
		12'h000, 12'h004, 12'h005, 12'h040, 12'h041, 12'h042, 12'h043, 12'h044,
		12'h100, 12'h102, 12'h103, 12'h104, 12'h105, 12'h140, 12'h141, 12'h142,
		12'h143, 12'h144, 12'h180, 12'h301, 12'hF11, 12'hF12, 12'hF13, 12'hF14,
		12'h300, 12'h302, 12'h303, 12'h304, 12'h305, 12'h340, 12'h341, 12'h342,
		12'h343, 12'h344, 12'h3A0, 12'h3A1
	};

	localparam logic [1:0] CSR_MIN_MODE [TABLE_LEN] = '{
		2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
		2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd2, 2'd2, 2'd2, 2'd2
	};

	// What the back has to do with an item.
	typedef enum logic [2:0] {
		K_INVALID,
		K_ECALL,
		K_SRET,
		K_MRET,
		K_CSRW,
		K_CSRR
	} pcte_kind_t;

	// One classified item as it travels through the queue.
	typedef struct packed {
		pcte_kind_t            kind;
		logic                  found;
		logic [CSR_IX_W-1:0]   csr_ix;
		logic [1:0]            min_mode;
		logic [4:0]            rd;
		logic [63:0]           pc;
		logic [63:0]           wdata;
	} pcte_item_t;

	// Queue fill status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} pcte_q_status_t;

	function automatic logic csr_in_range(logic [CSR_IX_W-1:0] ix);
		return int'(ix) < NUM_CSRS;
	endfunction

	function automatic logic [63:0] csr_reset_value(logic [CSR_IX_W-1:0] ix);
		return (ix == IX_VENDOR) ? VENDOR_ID : 64'd0;
	endfunction

endpackage

FILE: src/pcte_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Depends on pcte_pkg for the item type and the depth.
module pcte_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  pcte_pkg::pcte_item_t     push_item,
	input  logic                     pop,
	output pcte_pkg::pcte_item_t     head_item,
	output pcte_pkg::pcte_q_status_t status
);
	import pcte_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pcte_item_t        slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head_item    = slots_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: src/pcte_front.sv
// Input side: takes items from the stream, decodes the instruction and looks
// up the CSR address code. Depends on pcte_pkg for the tables and item type.
module pcte_front (
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: instr_word[31:0], pc[95:32], rs1_value[159:96]
	input  logic [pcte_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// tuser: op[0]
	input  logic [pcte_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	input  pcte_pkg::pcte_q_status_t      q_status,
	output logic                          q_push,
	output pcte_pkg::pcte_item_t          q_item
);
	import pcte_pkg::*;

	logic        op;
	logic [31:0] instr;
	logic [63:0] pc;
	logic [63:0] rs1_value;
	logic [4:0]  rd;
	logic [2:0]  funct3;
	logic [4:0]  rs1;
	logic [11:0] field;

	assign op        = s_axis_tuser[0];
	assign instr     = s_axis_tdata[31:0];
	assign pc        = s_axis_tdata[95:32];
	assign rs1_value = s_axis_tdata[159:96];

	assign rd     = instr[11:7];
	assign funct3 = instr[14:12];
	assign rs1    = instr[19:15];
	assign field  = instr[31:20];

	assign s_axis_tready = !q_status.full;
	assign q_push        = s_axis_tvalid && !q_status.full;

	always_comb begin
		q_item          = '0;
		q_item.rd       = rd;
		q_item.pc       = pc;
		// Register 0 always reads as zero.
		q_item.wdata    = (rs1 == 5'd0) ? 64'd0 : rs1_value;

		if (op) begin
			q_item.kind = K_ECALL;
		end else if (funct3 == F3_SYSTEM && field == SRET_FIELD) begin
			q_item.kind = K_SRET;
		end else if (funct3 == F3_SYSTEM && field == MRET_FIELD) begin
			q_item.kind = K_MRET;
		end else if (funct3 == F3_CSRW) begin
			q_item.kind = K_CSRW;
		end else if (funct3 == F3_CSRR) begin
			q_item.kind = K_CSRR;
		end else begin
			q_item.kind = K_INVALID;
		end

		// The codes are fixed, so the lookup is one compare per entry.
		for (int i = 0; i < TABLE_LEN; i++) begin
			if (i < NUM_CSRS && !q_item.found && CSR_CODE[i] == field) begin
				q_item.found    = 1'b1;
				q_item.csr_ix   = CSR_IX_W'(i);
				q_item.min_mode = CSR_MIN_MODE[i];
			end
		end
	end

endmodule

FILE: src/pcte_back.sv
// Execution side: holds the CSR store and privilege mode, carries out each
// item and drives the result stream. Depends on pcte_pkg.
module pcte_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcte_pkg::pcte_item_t          q_item,
	input  pcte_pkg::pcte_q_status_t      q_status,
	output logic                          q_pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: next_pc[63:0], rd_write[64], rd_index[69:65], rd_value[133:70],
	//        kill[134], mode_now[136:135], zero fill above
	output logic [pcte_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import pcte_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} pcte_back_state_t;

	pcte_back_state_t     state_q;
	logic [1:0]           mode_q;
	logic [NUM_CSRS-1:0]  valid_q;
	logic [63:0]          mem_q [NUM_CSRS];

	pcte_item_t           item_q;
	logic [CSR_IX_W-1:0]  addr_a_q;
	logic [CSR_IX_W-1:0]  addr_b_q;
	logic [63:0]          raw_a_q;
	logic [63:0]          raw_b_q;

	logic                 out_valid_q;
	logic [63:0]          out_npc_q;
	logic                 out_rdw_q;
	logic [4:0]           out_rdi_q;
	logic [63:0]          out_rdv_q;
	logic                 out_kill_q;
	logic [1:0]           out_mode_q;

	logic [CSR_IX_W-1:0]  raddr_a;
	logic [CSR_IX_W-1:0]  raddr_b;
	logic [63:0]          opa;
	logic [63:0]          opb;

	logic                 exec;
	logic                 wr_req;
	logic                 wr_en;
	logic [CSR_IX_W-1:0]  waddr;
	logic [63:0]          wdata;
	logic [63:0]          npc;
	logic                 rdw;
	logic [63:0]          rdv;
	logic                 kill;
	logic [1:0]           mode_next;
	logic                 priv_ok;

	// Take an item only when the result register is, or is about to be, free.
	assign q_pop = (state_q == ST_IDLE) && !q_status.empty
		&& (!out_valid_q || m_axis_tready);
	assign exec  = (state_q == ST_EXEC);

	always_comb begin
		raddr_a = q_item.csr_ix;
		raddr_b = IX_SEPC;
		case (q_item.kind)
			K_ECALL: begin
				raddr_a = IX_STVEC;
			end
			K_SRET: begin
				raddr_a = IX_SSTATUS;
				raddr_b = IX_SEPC;
			end
			K_MRET: begin
				raddr_a = IX_MSTATUS;
				raddr_b = IX_MEPC;
			end
			default: begin
				raddr_a = q_item.csr_ix;
			end
		endcase
	end

	// Registered two-port read of the store, issued as the item is taken.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q   <= q_item;
			addr_a_q <= raddr_a;
			addr_b_q <= raddr_b;
			raw_a_q  <= mem_q[raddr_a[MEM_AW-1:0]];
			raw_b_q  <= mem_q[raddr_b[MEM_AW-1:0]];
		end
		if (wr_en) begin
			mem_q[waddr[MEM_AW-1:0]] <= wdata;
		end
	end

	// An entry not written since reset reads as its reset value.
	assign opa = !csr_in_range(addr_a_q) ? 64'd0 :
		valid_q[addr_a_q[MEM_AW-1:0]] ? raw_a_q : csr_reset_value(addr_a_q);
	assign opb = !csr_in_range(addr_b_q) ? 64'd0 :
		valid_q[addr_b_q[MEM_AW-1:0]] ? raw_b_q : csr_reset_value(addr_b_q);

	always_comb begin
		wr_req    = 1'b0;
		waddr     = item_q.csr_ix;
		wdata     = item_q.wdata;
		npc       = item_q.pc;
		rdw       = 1'b0;
		rdv       = 64'd0;
		kill      = 1'b0;
		mode_next = mode_q;
		priv_ok   = item_q.found && (mode_q >= item_q.min_mode);
		case (item_q.kind)
			K_ECALL: begin
				wr_req    = 1'b1;
				waddr     = IX_SEPC;
				wdata     = item_q.pc;
				npc       = opa;
				mode_next = MODE_S;
			end
			K_SRET: begin
				if (mode_q == MODE_S || mode_q == MODE_M) begin
					wr_req           = 1'b1;
					waddr            = IX_SSTATUS;
					wdata            = opa;
					wdata[SPP_BIT]   = 1'b0;
					wdata[SPIE_POS]  = 1'b0;
					wdata[SIE_BIT]   = opa[SPIE_POS];
					npc              = opb;
					mode_next        = {1'b0, opa[SPP_BIT]};
				end else begin
					kill = 1'b1;
				end
			end
			K_MRET: begin
				if (mode_q == MODE_M) begin
					wr_req                = 1'b1;
					waddr                 = IX_MSTATUS;
					wdata                 = opa;
					wdata[MPP_HI:MPP_LO]  = 2'b00;
					wdata[MPIE_POS]       = 1'b0;
					wdata[MIE_BIT]        = opa[MPIE_POS];
					npc                   = opb;
					// Both upper MPP codes return to machine mode.
					mode_next = opa[MPP_HI] ? MODE_M : {1'b0, opa[MPP_LO]};
				end else begin
					kill = 1'b1;
				end
			end
			K_CSRW: begin
				npc = item_q.pc + 64'd4;
				if (priv_ok) begin
					wr_req = 1'b1;
				end else begin
					kill = 1'b1;
				end
			end
			K_CSRR: begin
				npc = item_q.pc + 64'd4;
				if (!priv_ok) begin
					kill = 1'b1;
				end else if (item_q.rd != 5'd0) begin
					rdw = 1'b1;
					rdv = opa;
				end
			end
			default: begin
				kill = 1'b1;
			end
		endcase
	end

	assign wr_en = exec && wr_req && csr_in_range(waddr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_M;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					mode_q  <= mode_next;
					if (wr_en) begin
						valid_q[waddr[MEM_AW-1:0]] <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_npc_q  <= npc;
			out_rdw_q  <= rdw;
			out_rdi_q  <= rdw ? item_q.rd : 5'd0;
			out_rdv_q  <= rdv;
			out_kill_q <= kill;
			out_mode_q <= mode_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), out_mode_q, out_kill_q,
		out_rdv_q, out_rdi_q, out_rdw_q, out_npc_q};

endmodule

FILE: src/privileged_csr_trap_emulator_core.sv
// The back takes one item at a time from the queue: it reads the CSR store, registered, as it
// takes the item, then executes and writes back, and takes no new item before that is done or
// while a result is held up by the receiver.
// The front takes items whenever the two-entry queue has room, also while a result waits.
// Reset (arst_n low, asynchronous) empties the queue, drops any pending result, enters machine
// mode and marks every CSR entry as holding its reset value; no clearing pass follows.
`include "privileged_csr_trap_emulator_core_macros.svh"

module privileged_csr_trap_emulator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: instr_word[31:0], pc[95:32], rs1_value[159:96]
	input  logic [pcte_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// tuser: op[0] (0 trapped instruction, 1 environment call)
	input  logic [pcte_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: next_pc[63:0], rd_write[64], rd_index[69:65], rd_value[133:70],
	//        kill[134], mode_now[136:135], zero fill up to bit 143
	output logic [pcte_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import pcte_pkg::*;

	// The front decodes each item and looks up its CSR code; the result is a
	// classified item that waits in the queue until the back is free.
	logic           q_push;
	logic           q_pop;
	pcte_item_t     q_in_item;
	pcte_item_t     q_head_item;
	pcte_q_status_t q_status;

	pcte_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_item        (q_in_item)
	);

	pcte_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in_item),
		.pop       (q_pop),
		.head_item (q_head_item),
		.status    (q_status)
	);

	// The back owns all architectural state: the CSR store, its valid bits
	// and the privilege mode. It handles one item at a time, reading the
	// store as it takes the item and writing it back in the execute state,
	// before it can take the next, so no read can see a stale value.
	pcte_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (q_head_item),
		.q_status      (q_status),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// The front must never push into a full queue, nor the back pop an empty one.
	`PCTE_ASSERT_NOW(a_push_not_full, q_push, !q_status.full, "push into full queue")
	`PCTE_ASSERT_NOW(a_pop_not_empty, q_pop, !q_status.empty, "pop from empty queue")
	// An accepted item is held in the queue in the following cycle.
	`PCTE_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, !q_status.empty,
		"accepted item missing from queue")
	// A killed item never writes a destination register.
	`PCTE_ASSERT_NOW(a_kill_no_write, m_axis_tvalid && m_axis_tdata[134], !m_axis_tdata[64],
		"killed item writes rd")

endmodule

FILE: bench/pcte_retire_checker.sv
// Checker for the privileged CSR trap emulator: watches both stream channels, predicts each
// result from its own model of the CSR file and privilege mode, and compares field by field.
// Depends on pcte_pkg for the CSR table, the fixed entry indexes and the status bit positions.
module pcte_retire_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	// tdata: instr_word[31:0], pc[95:32], rs1_value[159:96]
	input  logic [pcte_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: op[0]
	input  logic [pcte_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata: next_pc, rd_write, rd_index, rd_value, kill, mode_now, zero fill
	input  logic [pcte_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                               mismatches,
	output int                               outstanding
);
	import pcte_pkg::*;

	// One result as it sits on the output tdata, highest field first.
	typedef struct packed {
		logic [OUT_TDATA_W-OUT_BITS-1:0] fill;
		logic [1:0]                      mode_now;
		logic                            kill;
		logic [63:0]                     rd_value;
		logic [4:0]                      rd_index;
		logic                            rd_write;
		logic [63:0]                     next_pc;
	} retire_t;

	logic [63:0] csr_file [NUM_CSRS];
	logic [1:0]  cur_mode;
	retire_t     retire_q [$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 100) begin
			$display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	function automatic int find_csr(input logic [11:0] code);
		for (int i = 0; i < TABLE_LEN && i < NUM_CSRS; i++) begin
			if (CSR_CODE[i] == code) return i;
		end
		return -1;
	endfunction

	// Applies one item to the model state and gives the result it must produce.
	task automatic emulate_trap(input logic op, input logic [31:0] w, input logic [63:0] pc,
			input logic [63:0] rs1v, output retire_t r);
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [4:0]  rs1;
		logic [11:0] field;
		logic [63:0] st;
		logic [1:0]  back_mode;
		int          ix;
		rd    = w[11:7];
		f3    = w[14:12];
		rs1   = w[19:15];
		field = w[31:20];
		r = '0;
		r.next_pc = pc;
		if (op) begin
			csr_file[IX_SEPC] = pc;
			r.next_pc = csr_file[IX_STVEC];
			cur_mode = MODE_S;
		end else if (f3 == F3_SYSTEM && field == SRET_FIELD) begin
			if (cur_mode == MODE_S || cur_mode == MODE_M) begin
				st = csr_file[IX_SSTATUS];
				back_mode = {1'b0, st[SPP_BIT]};
				st[SIE_BIT]  = st[SPIE_POS];
				st[SPIE_POS] = 1'b0;
				st[SPP_BIT]  = 1'b0;
				csr_file[IX_SSTATUS] = st;
				r.next_pc = csr_file[IX_SEPC];
				cur_mode = back_mode;
			end else begin
				r.kill = 1'b1;
			end
		end else if (f3 == F3_SYSTEM && field == MRET_FIELD) begin
			if (cur_mode == MODE_M) begin
				st = csr_file[IX_MSTATUS];
				back_mode = st[MPP_HI:MPP_LO];
				st[MIE_BIT]  = st[MPIE_POS];
				st[MPIE_POS] = 1'b0;
				st[MPP_HI:MPP_LO] = 2'b00;
				csr_file[IX_MSTATUS] = st;
				r.next_pc = csr_file[IX_MEPC];
				cur_mode = (back_mode >= MODE_M) ? MODE_M : back_mode;
			end else begin
				r.kill = 1'b1;
			end
		end else if (f3 == F3_CSRW || f3 == F3_CSRR) begin
			ix = find_csr(field);
			r.next_pc = pc + 64'd4;
			if (ix < 0) begin
				r.kill = 1'b1;
			end else if (cur_mode < CSR_MIN_MODE[ix]) begin
				r.kill = 1'b1;
			end else if (f3 == F3_CSRW) begin
				csr_file[ix] = (rs1 == 5'd0) ? 64'd0 : rs1v;
			end else if (rd != 5'd0) begin
				r.rd_write = 1'b1;
				r.rd_index = rd;
				r.rd_value = csr_file[ix];
			end
		end else begin
			r.kill = 1'b1;
		end
		r.mode_now = cur_mode;
	endtask

	always @(posedge clk or negedge arst_n) begin
		retire_t got;
		retire_t want;
		if (!arst_n) begin
			retire_q.delete();
			for (int i = 0; i < NUM_CSRS; i++) csr_file[i] = 64'd0;
			csr_file[IX_VENDOR] = VENDOR_ID;
			cur_mode = MODE_M;
			outstanding <= 0;
		end else begin
			// Results are taken before items so that a queue emptied this edge is seen right.
			if (m_axis_tvalid && m_axis_tready) begin
				got = retire_t'(m_axis_tdata);
				if (retire_q.size() == 0) begin
					report_mismatch("unexpected result, next_pc", got.next_pc, 64'd0);
				end else begin
					want = retire_q.pop_front();
					if (got.next_pc !== want.next_pc)
						report_mismatch("next_pc", got.next_pc, want.next_pc);
					if (got.rd_write !== want.rd_write)
						report_mismatch("rd_write", 64'(got.rd_write), 64'(want.rd_write));
					if (got.rd_index !== want.rd_index)
						report_mismatch("rd_index", 64'(got.rd_index), 64'(want.rd_index));
					if (got.rd_value !== want.rd_value)
						report_mismatch("rd_value", got.rd_value, want.rd_value);
					if (got.kill !== want.kill)
						report_mismatch("kill", 64'(got.kill), 64'(want.kill));
					if (got.mode_now !== want.mode_now)
						report_mismatch("mode_now", 64'(got.mode_now), 64'(want.mode_now));
					if (got.fill !== want.fill)
						report_mismatch("zero fill", 64'(got.fill), 64'(want.fill));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				emulate_trap(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[95:32],
					s_axis_tdata[159:96], want);
				retire_q.push_back(want);
			end
			outstanding <= retire_q.size();
		end
	end

endmodule

FILE: bench/tb_privileged_csr_trap_emulator_core.sv
// Top of the testbench for the privileged CSR trap emulator core: clock, reset, stimulus,
// output back-pressure, a stall watchdog and the verdict.
// Depends on pcte_pkg, the core itself and pcte_retire_checker, which does all the checking.
module tb_privileged_csr_trap_emulator_core;
	import pcte_pkg::*;

	// CSR address codes that the directed part names.
	localparam logic [11:0] CSR_USTATUS   = 12'h000;
	localparam logic [11:0] CSR_SSTATUS   = 12'h100;
	localparam logic [11:0] CSR_STVEC     = 12'h105;
	localparam logic [11:0] CSR_SSCRATCH  = 12'h140;
	localparam logic [11:0] CSR_SEPC      = 12'h141;
	localparam logic [11:0] CSR_MSTATUS   = 12'h300;
	localparam logic [11:0] CSR_MEPC      = 12'h341;
	localparam logic [11:0] CSR_MVENDORID = 12'hF11;
	localparam logic [11:0] CSR_UNUSED    = 12'hFFF;

	// funct3 values that decode to no instruction at all.
	localparam logic [2:0] F3_BAD_LO = 3'd3;
	localparam logic [2:0] F3_BAD_HI = 3'd7;

	// Cycles with no item moving on either side before the run is declared hung.
	localparam int STALL_LIMIT = 2000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int mismatches;
	int outstanding;
	int stall_cycles = 0;
	int sink_hold = 0;
	// When set, neither the sender nor the receiver idles any more.
	bit quiet = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	privileged_csr_trap_emulator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pcte_retire_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// The receiver alternates between runs of readiness and idle bursts.
	// Everything changes on the falling edge so the core samples settled values.
	always @(negedge clk) begin
		if (quiet) begin
			m_axis_tready = 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold--;
		end else if (m_axis_tready && $urandom_range(0, 2) == 0) begin
			m_axis_tready = 1'b0;
			sink_hold = $urandom_range(0, 9);
		end else begin
			m_axis_tready = 1'b1;
			sink_hold = $urandom_range(0, 15);
		end
	end

	// The watchdog ends a run that has stopped moving: it only counts cycles in which no item
	// is accepted on either channel, so a long but healthy run never trips it.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [11:0] known_code();
		return CSR_CODE[$urandom_range(0, TABLE_LEN - 1)];
	endfunction

	// In machine mode the only way to stay there is an mret with MPP at 2 or 3, and machine
	// mode cannot be entered again later. Noise in that phase must therefore neither leave
	// machine mode nor overwrite mstatus behind the back of the mret sequence.
	function automatic bit keeps_machine(input logic [31:0] w);
		if (w[14:12] == F3_SYSTEM && (w[31:20] == SRET_FIELD || w[31:20] == MRET_FIELD))
			return 1'b0;
		if (w[14:12] == F3_CSRW && w[31:20] == CSR_MSTATUS)
			return 1'b0;
		return 1'b1;
	endfunction

	// Offers one item from a falling edge and returns on the falling edge after it has been
	// accepted, with tvalid still high so that back-to-back items never drop it in between.
	task automatic send_item(input logic op, input logic [31:0] w, input logic [63:0] pc,
			input logic [63:0] rs1v);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = {rs1v, pc, w};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Builds a trapped instruction word; the opcode bits are not decoded and stay random.
	task automatic send_instr(input logic [2:0] f3, input logic [11:0] field,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [63:0] rs1v,
			input logic [63:0] pc);
		send_item(1'b0, {field, rs1, f3, rd, 7'($urandom())}, pc, rs1v);
	endtask

	task automatic send_csrw(input logic [11:0] field, input logic [63:0] v);
		send_instr(F3_CSRW, field, 5'($urandom()), 5'($urandom_range(1, 31)), v, rand64());
	endtask

	task automatic send_csrr(input logic [11:0] field);
		send_instr(F3_CSRR, field, 5'($urandom_range(1, 31)), 5'($urandom()), rand64(), rand64());
	endtask

	task automatic send_mret();
		send_instr(F3_SYSTEM, MRET_FIELD, 5'($urandom()), 5'($urandom()), rand64(), rand64());
	endtask

	task automatic send_sret();
		send_instr(F3_SYSTEM, SRET_FIELD, 5'($urandom()), 5'($urandom()), rand64(), rand64());
	endtask

	// One random step while the core must stay in machine mode.
	task automatic machine_item();
		int          pick;
		logic [11:0] code;
		logic [31:0] w;
		logic [63:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_instr(F3_CSRR, known_code(), 5'($urandom()), 5'($urandom()), rand64(), rand64());
		end else if (pick < 70) begin
			do code = known_code(); while (code == CSR_MSTATUS);
			send_instr(F3_CSRW, code, 5'($urandom()), 5'($urandom()), rand64(), rand64());
		end else if (pick < 80) begin
			// mstatus with MPP at 2 or 3 and random other bits, then the mret that uses it.
			v = rand64();
			v[MPP_HI] = 1'b1;
			send_csrw(CSR_MSTATUS, v);
			send_mret();
		end else begin
			do w = $urandom(); while (!keeps_machine(w));
			send_item(1'b0, w, rand64(), rand64());
		end
	endtask

	// One random step once machine mode has been left: every kind of item is fair game.
	task automatic free_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_instr(F3_CSRR, known_code(), 5'($urandom()), 5'($urandom()), rand64(), rand64());
		end else if (pick < 55) begin
			send_instr(F3_CSRW, known_code(), 5'($urandom()), 5'($urandom()), rand64(), rand64());
		end else if (pick < 65) begin
			send_item(1'b1, $urandom(), rand64(), rand64());
		end else if (pick < 75) begin
			send_sret();
		end else if (pick < 80) begin
			send_mret();
		end else begin
			send_item(1'($urandom()), $urandom(), rand64(), rand64());
		end
	endtask

	initial begin
		logic [63:0] st;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, still in machine mode: the vendor id reset value, reads with and without
		// a destination, writes from register 0 and from a nonzero one, extreme values and pcs,
		// an unknown CSR, invalid funct3 codes and a system instruction that is neither return.
		send_instr(F3_CSRR, CSR_MVENDORID, 5'd1, 5'd0, '1, 64'd0);
		send_instr(F3_CSRR, CSR_MVENDORID, 5'd0, 5'd3, '1, 64'h100);
		send_instr(F3_CSRW, CSR_STVEC, 5'd0, 5'd1, '1, 64'h200);
		send_instr(F3_CSRR, CSR_STVEC, 5'd31, 5'd31, 64'd0, 64'h204);
		send_instr(F3_CSRW, CSR_SSCRATCH, 5'd7, 5'd0, '1, 64'h208);
		send_instr(F3_CSRR, CSR_SSCRATCH, 5'd9, 5'd0, 64'd0, 64'h20C);
		send_instr(F3_CSRW, CSR_SEPC, 5'd0, 5'd31, 64'd0, 64'h210);
		send_instr(F3_CSRW, CSR_MEPC, 5'd0, 5'd2, 64'h8000_0000_0000_0000, 64'h214);
		send_instr(F3_CSRR, CSR_UNUSED, 5'd4, 5'd0, 64'd0, '1);
		send_instr(F3_BAD_LO, CSR_SSTATUS, 5'd4, 5'd4, '1, 64'h218);
		send_instr(F3_BAD_HI, CSR_MVENDORID, 5'd31, 5'd31, '1, 64'h21C);
		send_instr(F3_SYSTEM, CSR_STVEC, 5'd0, 5'd0, 64'd0, 64'h220);
		// mret with MPP at 3 keeps machine mode and moves MPIE into MIE; then MPP at 2.
		st = '0;
		st[MPP_HI:MPP_LO] = 2'b11;
		st[MPIE_POS] = 1'b1;
		send_csrw(CSR_MSTATUS, st);
		send_mret();
		send_csrr(CSR_MSTATUS);
		st[MPP_HI:MPP_LO] = 2'b10;
		send_csrw(CSR_MSTATUS, st);
		send_mret();

		repeat (350) machine_item();

		// The sender holds off here until every result so far has come back.
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);

		// Directed, leaving machine mode: mret to supervisor, privilege faults there, sret
		// back to supervisor and down to user, faults in user mode and environment calls.
		st = '0;
		st[MPP_HI:MPP_LO] = MODE_S;
		send_csrw(CSR_MSTATUS, st);
		send_mret();
		send_csrr(CSR_MSTATUS);
		send_mret();
		send_csrr(CSR_SSTATUS);
		st = '0;
		st[SPP_BIT]  = 1'b1;
		st[SPIE_POS] = 1'b1;
		send_csrw(CSR_SSTATUS, st);
		send_sret();
		send_csrr(CSR_SSTATUS);
		send_csrw(CSR_SSTATUS, 64'd0);
		send_sret();
		send_sret();
		send_mret();
		send_csrr(CSR_USTATUS);
		send_csrw(CSR_SSTATUS, '1);
		send_csrw(CSR_USTATUS, '1);
		send_item(1'b1, 32'd0, '1, 64'd0);
		send_csrr(CSR_SEPC);
		send_item(1'b1, '1, 64'd0, '1);

		repeat (300) free_item();
		// The last stretch runs with both sides always willing.
		quiet = 1'b1;
		repeat (150) free_item();
		s_axis_tvalid = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: privileged_csr_trap_emulator_core.f
+incdir+src
src/pcte_pkg.sv
src/pcte_queue.sv
src/pcte_front.sv
src/pcte_back.sv
src/privileged_csr_trap_emulator_core.sv
bench/pcte_retire_checker.sv
bench/tb_privileged_csr_trap_emulator_core.sv
